/* rtl/ole_pkg.sv */
`default_nettype none

package ole_pkg;

    // Default sizing of the list
    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    // Field widths on the stream ports
    localparam int ACTION_W = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 5;

    // Index reported when find has no match, and for every other action
    localparam logic [INDEX_W-1:0] FOUND_NONE = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_BACK   = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_INSERT     = 3'd4,
        ACT_ERASE      = 3'd5,
        ACT_FIND       = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_UP   = 3'd1,
        S_PUT  = 3'd2,
        S_DOWN = 3'd3,
        S_FIND = 3'd4,
        S_RESP = 3'd5
    } t_state;

    typedef struct packed {
        t_action              action;
        logic [POS_W-1:0]     position;
        logic [VALUE_W-1:0]   value;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   found_index;
        logic [COUNT_W-1:0]   element_count;
    } t_res;

endpackage

`default_nettype wire

/* rtl/ordered_list_engine.sv */
`default_nettype none
// Push back, pop back, failed requests and find on an empty list go straight to the
// result; insert below the top moves the cells up one by one, then writes the word;
// erase below the top moves the cells above it down; find compares from index 0 up to
// the first match or last cell. One cell moves or compares per cycle; the next word is
// taken once the previous result sits in the output register.
// Reset (synchronous, active low) empties the list and the output; cells are not cleared.

module ordered_list_engine #(
    parameter int DEPTH     = ole_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ole_pkg::WORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero[39:37]
    input  wire logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // found_index[4:0], element_count[9:5], zero
    output logic      [1:0]  m_axis_tuser    // status[1:0]
);

    import ole_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_req                 req;
    t_res                 res;
    logic                 res_valid;
    logic                 res_ready;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    logic                 r_m_valid;
    t_res                 r_m_res;

    // Unpack the input word
    assign req.action   = t_action'(s_axis_tuser);
    assign req.position = s_axis_tdata[POS_W-1:0];
    assign req.value    = s_axis_tdata[POS_W +: VALUE_W];

    ole_seq #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    ole_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: take a result when empty or being drained
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    // Pack the result word
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = {6'd0, r_m_res.element_count, r_m_res.found_index};

endmodule

`default_nettype wire

/* rtl/ole_mem.sv */
`default_nettype none

module ole_mem #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int AW        = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic [WORD_BITS-1:0] i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic      [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one cell into the output register
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/ole_seq.sv */
`default_nettype none

module ole_seq #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int AW        = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ole_pkg::t_req        i_req,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    output ole_pkg::t_res             o_res,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output logic                      o_wr_en,
    output logic      [AW-1:0]        o_wr_addr,
    output logic      [WORD_BITS-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic      [AW-1:0]        o_rd_addr,
    input  wire logic [WORD_BITS-1:0] i_rd_data
);

    import ole_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_pos, n_pos;
    logic [WORD_BITS-1:0] r_word, n_word;
    t_status              r_status, n_status;
    logic [INDEX_W-1:0]   r_found, n_found;

    logic [63:0]          val64;
    logic [WORD_BITS-1:0] req_word;
    logic [PW-1:0]        pos_ext;
    logic [PW-1:0]        cnt_ext;
    logic [PW-1:0]        ins_pos;
    logic [PW-1:0]        era_pos;
    logic                 is_full;
    logic                 is_empty;

    // Request decode
    assign val64    = 64'(i_req.value);
    assign req_word = val64[WORD_BITS-1:0];
    assign pos_ext  = PW'(i_req.position);
    assign cnt_ext  = PW'(r_count);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Target place of the add and remove actions
    always_comb begin
        case (i_req.action)
            ACT_PUSH_BACK:  ins_pos = cnt_ext;
            ACT_PUSH_FRONT: ins_pos = '0;
            default:        ins_pos = pos_ext;
        endcase
        case (i_req.action)
            ACT_POP_BACK:   era_pos = cnt_ext - PW'(1);
            ACT_POP_FRONT:  era_pos = '0;
            default:        era_pos = pos_ext;
        endcase
    end

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_status <= n_status;
        r_found  <= n_found;
    end

    // Sequencer: one cell moved or compared per cycle
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_word    = r_word;
        n_status  = r_status;
        n_found   = r_found;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_word   = req_word;
                    n_status = ST_OK;
                    n_found  = FOUND_NONE;
                    n_state  = S_RESP;
                    case (i_req.action) inside
                        ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
                            n_pos = AW'(ins_pos);
                            if (ins_pos > cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else if (ins_pos == cnt_ext) begin
                                // append: write the cell in place
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(r_count);
                                o_wr_data = req_word;
                                n_count   = r_count + CW'(1);
                            end else begin
                                // open a gap from the top down
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(r_count - CW'(1));
                                n_idx     = AW'(r_count);
                                n_state   = S_UP;
                            end
                        end
                        ACT_POP_BACK, ACT_POP_FRONT, ACT_ERASE: begin
                            if (i_req.action != ACT_ERASE && is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (era_pos >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (era_pos == cnt_ext - PW'(1)) begin
                                // last cell: drop it
                                n_count = r_count - CW'(1);
                            end else begin
                                // close the gap from the bottom up
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(era_pos + PW'(1));
                                n_idx     = AW'(era_pos);
                                n_state   = S_DOWN;
                            end
                        end
                        ACT_FIND: begin
                            if (!is_empty) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_idx     = '0;
                                n_state   = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP: begin
                // move the cell below up into this place
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = i_rd_data;
                if (r_idx - AW'(1) == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx - AW'(2);
                    n_idx     = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos;
                o_wr_data = r_word;
                n_count   = r_count + CW'(1);
                n_state   = S_RESP;
            end
            S_DOWN: begin
                // move the cell above down into this place
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = i_rd_data;
                if (CW'(r_idx) + CW'(1) == r_count - CW'(1)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(2);
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_FIND: begin
                // compare one cell, stop at the first match
                if (i_rd_data == r_word) begin
                    n_found = INDEX_W'(r_idx);
                    n_state = S_RESP;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_state = S_RESP;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Handshake and result
    assign o_req_ready         = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_RESP);
    assign o_res.status        = r_status;
    assign o_res.found_index   = r_found;
    assign o_res.element_count = COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))))
        else $error("element count moved by more than one");

    a_find_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> (CW'(r_idx) < r_count))
        else $error("find scan beyond stored cells");

    a_port_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("read and write hit the same cell");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> ((r_state != S_RESP) && (r_state != S_FIND)))
        else $error("cell write outside an update");

endmodule

`default_nettype wire
